/* rtl/swh_pkg.sv */
// ----------------------------------------------------------------------------
// swh_pkg
// Types and constants shared by the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
`default_nettype none

package swh_pkg;

  // Received word widths, fixed by the result fields, and the timer width
  localparam int unsigned DataW  = 32;
  localparam int unsigned CheckW = 8;
  localparam int unsigned TimerW = 20;
  localparam int unsigned ByteW  = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_LOW    = 3'd0,
    CFG_RELEASE_WAIT = 3'd1,
    CFG_SAMPLE_DELAY = 3'd2,
    CFG_TEMP_LIMIT   = 3'd3,
    CFG_MAX_ATTEMPTS = 3'd4,
    CFG_RETRY_GAP    = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [15:0]       START_LOW_RST    = 16'd25000;
  localparam logic [7:0]        RELEASE_WAIT_RST = 8'd35;
  localparam logic [7:0]        SAMPLE_DELAY_RST = 8'd32;
  localparam logic [7:0]        TEMP_LIMIT_RST   = 8'd50;
  localparam logic [2:0]        MAX_ATTEMPTS_RST = 3'd5;
  localparam logic [TimerW-1:0] RETRY_GAP_RST    = 20'd500000;

  typedef struct packed {
    logic [15:0]       start_low_us;
    logic [7:0]        release_wait_us;
    logic [7:0]        sample_delay_us;
    logic [7:0]        temp_limit;
    logic [2:0]        max_attempts;
    logic [TimerW-1:0] retry_gap_us;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RESP  = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_START_LOW = 8'b0000_0010,
    PH_RELEASE   = 8'b0000_0100,
    PH_RESP_HIGH = 8'b0000_1000,
    PH_BIT_LOW   = 8'b0001_0000,
    PH_BIT_HIGH  = 8'b0010_0000,
    PH_BIT_DELAY = 8'b0100_0000,
    PH_GAP       = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic             drive_low;
    logic             busy;
    logic             done;
    logic [1:0]       status;
    logic [ByteW-1:0] humidity_int;
    logic [ByteW-1:0] humidity_frac;
    logic [ByteW-1:0] temperature_int;
    logic [ByteW-1:0] temperature_frac;
    logic [ByteW-1:0] check_byte;
  } result_t;

endpackage

`default_nettype wire

/* rtl/single_wire_humidity_sensor_reader_top.sv */
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_top
// Single-wire humidity/temperature sensor reader, one item per microsecond.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i/in_ready_o  | command_i, line_level_i
//   out     | output    | out_valid_o/out_ready_i| drive_low_o .. check_byte_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each input item is one tick. It lands in an input register, the state
// machine in swh_core advances on it once the output register is free or
// being emptied, and the result is captured in the output register then:
// one item per cycle sustained while out does not stall, set by the single
// state update per tick. Reset clears the handshake flags, loads config
// defaults and idles the reader. When the output stalls, one more item waits
// in the input register; in_ready_o drops only while both registers are full
// and out is blocked. cfg_ready_o is always high; each write is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_humidity_sensor_reader_top #(
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned CHECK_BITS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         command_i,
  input  wire logic                         line_level_i,

  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         drive_low_o,
  output      logic                         busy_res_o,
  output      logic                         done_res_o,
  output      logic [1:0]                   status_o,
  output      logic [7:0]                   humidity_int_o,
  output      logic [7:0]                   humidity_frac_o,
  output      logic [7:0]                   temperature_int_o,
  output      logic [7:0]                   temperature_frac_o,
  output      logic [7:0]                   check_byte_o,

  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [swh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [swh_pkg::CfgDataW-1:0] cfg_data_i
);

  swh_pkg::cfg_t    cfg;
  swh_pkg::result_t step_res;
  swh_pkg::result_t res_q;

  logic in_full_q, in_full_d;
  logic out_full_q, out_full_d;
  logic cmd_q, line_q;
  logic advance;

  assign cfg_ready_o = 1'b1;

  swh_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // the held tick moves on when the result slot is free or being emptied
  assign advance    = in_full_q && (!out_full_q || out_ready_i);
  assign in_ready_o = !in_full_q || advance;

  always_comb begin
    in_full_d = in_full_q;
    if (in_valid_i && in_ready_o) in_full_d = 1'b1;
    else if (advance)            in_full_d = 1'b0;

    out_full_d = out_full_q;
    if (advance)          out_full_d = 1'b1;
    else if (out_ready_i) out_full_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_full_d;
      out_full_q <= out_full_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      line_q <= line_level_i;
    end
    if (advance) res_q <= step_res;
  end

  swh_core #(
    .DATA_BITS  (DATA_BITS),
    .CHECK_BITS (CHECK_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .command_i    (cmd_q),
    .line_level_i (line_q),
    .cfg_i        (cfg),
    .res_o        (step_res)
  );

  assign out_valid_o        = out_full_q;
  assign drive_low_o        = res_q.drive_low;
  assign busy_res_o         = res_q.busy;
  assign done_res_o         = res_q.done;
  assign status_o           = res_q.status;
  assign humidity_int_o     = res_q.humidity_int;
  assign humidity_frac_o    = res_q.humidity_frac;
  assign temperature_int_o  = res_q.temperature_int;
  assign temperature_frac_o = res_q.temperature_frac;
  assign check_byte_o       = res_q.check_byte;

endmodule

`default_nettype wire

/* rtl/swh_cfg.sv */
// ----------------------------------------------------------------------------
// swh_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module swh_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [swh_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  wire logic [swh_pkg::CfgDataW-1:0]  wr_data_i,
  output swh_pkg::cfg_t                      cfg_o
);

  swh_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        swh_pkg::CFG_START_LOW:    cfg_d.start_low_us    = wr_data_i[15:0];
        swh_pkg::CFG_RELEASE_WAIT: cfg_d.release_wait_us = wr_data_i[7:0];
        swh_pkg::CFG_SAMPLE_DELAY: cfg_d.sample_delay_us = wr_data_i[7:0];
        swh_pkg::CFG_TEMP_LIMIT:   cfg_d.temp_limit      = wr_data_i[7:0];
        swh_pkg::CFG_MAX_ATTEMPTS: cfg_d.max_attempts    = wr_data_i[2:0];
        swh_pkg::CFG_RETRY_GAP:    cfg_d.retry_gap_us    = wr_data_i[swh_pkg::TimerW-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_us    <= swh_pkg::START_LOW_RST;
      cfg_q.release_wait_us <= swh_pkg::RELEASE_WAIT_RST;
      cfg_q.sample_delay_us <= swh_pkg::SAMPLE_DELAY_RST;
      cfg_q.temp_limit      <= swh_pkg::TEMP_LIMIT_RST;
      cfg_q.max_attempts    <= swh_pkg::MAX_ATTEMPTS_RST;
      cfg_q.retry_gap_us    <= swh_pkg::RETRY_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/swh_core.sv */
// ----------------------------------------------------------------------------
// swh_core
// Reader state machine: one tick per step, result formed combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module swh_core #(
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned CHECK_BITS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           command_i,
  input  wire logic           line_level_i,
  input  swh_pkg::cfg_t       cfg_i,
  output swh_pkg::result_t    res_o
);

  localparam int unsigned TotalBits = DATA_BITS + CHECK_BITS;
  localparam int unsigned CntW      = $clog2(TotalBits + 1);
  localparam int unsigned TW        = swh_pkg::TimerW;

  swh_pkg::phase_e                phase_q, phase_d;
  logic [TW-1:0]                  timer_q, timer_d;
  logic [CntW-1:0]                bit_cnt_q, bit_cnt_d;
  logic [swh_pkg::DataW-1:0]      data_q, data_d;
  logic [swh_pkg::CheckW-1:0]     check_q, check_d;
  logic [2:0]                     attempts_q, attempts_d;
  logic                           done;
  swh_pkg::status_e               status;
  logic                           timer_zero;

  assign timer_zero = (timer_q == '0);

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_zero ? timer_q : timer_q - TW'(1);
    bit_cnt_d  = bit_cnt_q;
    data_d     = data_q;
    check_d    = check_q;
    attempts_d = attempts_q;
    done       = 1'b0;
    status     = swh_pkg::ST_OK;

    case (phase_q)
      swh_pkg::PH_START_LOW: begin
        if (timer_zero) begin
          phase_d = swh_pkg::PH_RELEASE;
          timer_d = TW'(cfg_i.release_wait_us);
        end
      end
      swh_pkg::PH_RELEASE: begin
        if (timer_zero) begin
          if (!line_level_i) begin
            phase_d = swh_pkg::PH_RESP_HIGH;
          end else begin
            done   = 1'b1;
            status = swh_pkg::ST_NO_RESP;
          end
        end
      end
      swh_pkg::PH_RESP_HIGH: begin
        if (line_level_i) phase_d = swh_pkg::PH_BIT_LOW;
      end
      swh_pkg::PH_BIT_LOW: begin
        if (!line_level_i) phase_d = swh_pkg::PH_BIT_HIGH;
      end
      swh_pkg::PH_BIT_HIGH: begin
        if (line_level_i) begin
          phase_d = swh_pkg::PH_BIT_DELAY;
          timer_d = TW'(cfg_i.sample_delay_us);
        end
      end
      swh_pkg::PH_BIT_DELAY: begin
        if (timer_zero) begin
          if (bit_cnt_q < CntW'(DATA_BITS)) begin
            data_d = {data_q[swh_pkg::DataW-2:0], line_level_i};
          end else begin
            check_d = {check_q[swh_pkg::CheckW-2:0], line_level_i};
          end
          bit_cnt_d = bit_cnt_q + CntW'(1);
          if (bit_cnt_d >= CntW'(TotalBits)) begin
            // temperature integer byte decides accept or retry
            if (data_d[15:8] > cfg_i.temp_limit) begin
              attempts_d = attempts_q - 3'd1;
              phase_d    = swh_pkg::PH_GAP;
              timer_d    = cfg_i.retry_gap_us;
            end else begin
              done   = 1'b1;
              status = swh_pkg::ST_OK;
            end
          end else begin
            phase_d = swh_pkg::PH_BIT_LOW;
          end
        end
      end
      swh_pkg::PH_GAP: begin
        if (timer_zero) begin
          if (attempts_q == 3'd0) begin
            done   = 1'b1;
            status = swh_pkg::ST_REJECTED;
          end else begin
            data_d    = '0;
            check_d   = '0;
            bit_cnt_d = '0;
            phase_d   = swh_pkg::PH_START_LOW;
            timer_d   = TW'(cfg_i.start_low_us);
          end
        end
      end
      default: begin
        // idle, and any stray code recovers as idle
        phase_d = swh_pkg::PH_IDLE;
        if (command_i) begin
          attempts_d = cfg_i.max_attempts;
          if (cfg_i.max_attempts == 3'd0) begin
            data_d  = '0;
            check_d = '0;
            done    = 1'b1;
            status  = swh_pkg::ST_REJECTED;
          end else begin
            data_d    = '0;
            check_d   = '0;
            bit_cnt_d = '0;
            phase_d   = swh_pkg::PH_START_LOW;
            timer_d   = TW'(cfg_i.start_low_us);
          end
        end
      end
    endcase

    if (done) phase_d = swh_pkg::PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= swh_pkg::PH_IDLE;
      timer_q    <= '0;
      bit_cnt_q  <= '0;
      data_q     <= '0;
      check_q    <= '0;
      attempts_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      bit_cnt_q  <= bit_cnt_d;
      data_q     <= data_d;
      check_q    <= check_d;
      attempts_q <= attempts_d;
    end
  end

  always_comb begin
    res_o.drive_low        = (phase_d == swh_pkg::PH_START_LOW);
    res_o.busy             = (phase_d != swh_pkg::PH_IDLE);
    res_o.done             = done;
    res_o.status           = done ? status : swh_pkg::ST_OK;
    res_o.humidity_int     = done ? data_d[31:24] : '0;
    res_o.humidity_frac    = done ? data_d[23:16] : '0;
    res_o.temperature_int  = done ? data_d[15:8]  : '0;
    res_o.temperature_frac = done ? data_d[7:0]   : '0;
    res_o.check_byte       = done ? check_d       : '0;
  end

  // finishing tick always returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> !res_o.busy)
    else $error("done with busy still set");

  // line is only pulled low inside a reading
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.drive_low |-> res_o.busy)
    else $error("drive_low outside a reading");

  // bit counter never runs past the frame
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= CntW'(TotalBits))
    else $error("bit counter past frame length");

  // a step in the gap with time left keeps waiting
  a_gap_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == swh_pkg::PH_GAP && !timer_zero)
      |=> (phase_q == swh_pkg::PH_GAP && timer_q == $past(timer_q) - TW'(1)))
    else $error("gap wait left early");

endmodule

`default_nettype wire
